// ===== hdl/htfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 byte update for the humidity and
// temperature frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

    localparam logic [7:0] CrcInit = 8'hFF;
    localparam logic [7:0] CrcPoly = 8'h31;

    localparam int TempW = 15;
    localparam int HumW  = 14;
    localparam int WordW = 16;

    // byte position inside a six-byte reply
    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } t_pos;

    // completed frame handed from the byte tracker to the scaler
    typedef struct packed {
        logic             done;
        logic             ok;
        logic [WordW-1:0] temp_raw;
        logic [WordW-1:0] humid_raw;
    } t_frame;

    typedef struct packed {
        logic signed [TempW-1:0] temp_centi;
        logic [HumW-1:0]         humidity_centi;
        logic                    crc_ok;
        logic                    have_reading;
    } t_result;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/htfd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_if
// Valid/ready channels of the frame decoder: received bytes in, readings out.
// ----------------------------------------------------------------------------
interface htfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface htfd_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [htfd_pkg::TempW-1:0] temp_centi;
    logic [htfd_pkg::HumW-1:0]         humidity_centi;
    logic                              crc_ok;
    logic                              have_reading;

    modport source (output valid, output temp_centi, output humidity_centi,
                    output crc_ok, output have_reading, input ready);
    modport sink   (input valid, input temp_centi, input humidity_centi,
                    input crc_ok, input have_reading, output ready);
endinterface
`default_nettype wire

// ===== hdl/htfd_frame.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_frame
// Byte position tracking, raw word capture and CRC-8 checking of the reply.
// ----------------------------------------------------------------------------
module htfd_frame (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_rx_byte,
    input  wire logic             i_frame_start,
    output htfd_pkg::t_frame      o_frame
);

    htfd_pkg::t_pos r_pos, n_pos;
    htfd_pkg::t_pos w_pos;
    logic [7:0]     r_crc, n_crc;
    logic [7:0]     r_high, n_high;
    logic [15:0]    r_temp_raw, n_temp_raw;
    logic [15:0]    r_humid_raw, n_humid_raw;
    logic           r_temp_good, n_temp_good;
    logic           w_crc_match;

    assign w_pos       = i_frame_start ? htfd_pkg::POS_T_HI : r_pos;
    assign w_crc_match = (r_crc == i_rx_byte);

    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_high      = r_high;
        n_temp_raw  = r_temp_raw;
        n_humid_raw = r_humid_raw;
        n_temp_good = r_temp_good;
        if (i_accept) begin
            unique case (w_pos)
                htfd_pkg::POS_T_HI, htfd_pkg::POS_H_HI: begin
                    n_crc  = htfd_pkg::crc8_update(htfd_pkg::CrcInit, i_rx_byte);
                    n_high = i_rx_byte;
                    n_pos  = (w_pos == htfd_pkg::POS_T_HI) ? htfd_pkg::POS_T_LO
                                                           : htfd_pkg::POS_H_LO;
                end
                htfd_pkg::POS_T_LO: begin
                    n_crc      = htfd_pkg::crc8_update(r_crc, i_rx_byte);
                    n_temp_raw = {r_high, i_rx_byte};
                    n_pos      = htfd_pkg::POS_T_CRC;
                end
                htfd_pkg::POS_T_CRC: begin
                    n_temp_good = w_crc_match;
                    n_pos       = htfd_pkg::POS_H_HI;
                end
                htfd_pkg::POS_H_LO: begin
                    n_crc       = htfd_pkg::crc8_update(r_crc, i_rx_byte);
                    n_humid_raw = {r_high, i_rx_byte};
                    n_pos       = htfd_pkg::POS_H_CRC;
                end
                default: begin
                    n_pos = htfd_pkg::POS_T_HI;
                end
            endcase
        end
    end

    always_comb begin
        o_frame.done      = i_accept && (w_pos == htfd_pkg::POS_H_CRC);
        o_frame.ok        = r_temp_good && w_crc_match;
        o_frame.temp_raw  = r_temp_raw;
        o_frame.humid_raw = r_humid_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= htfd_pkg::POS_T_HI;
            r_crc       <= htfd_pkg::CrcInit;
            r_temp_good <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_temp_good <= n_temp_good;
        end
    end

    always_ff @(posedge i_clk) begin
        r_high      <= n_high;
        r_temp_raw  <= n_temp_raw;
        r_humid_raw <= n_humid_raw;
    end

endmodule
`default_nettype wire

// ===== hdl/htfd_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_scale
// Scaling of the checked raw words, hold of the last good reading and the
// output register.
// ----------------------------------------------------------------------------
module htfd_scale (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire htfd_pkg::t_frame  i_frame,
    input  wire logic              i_out_ready,
    output logic                   o_stall,
    output logic                   o_out_valid,
    output htfd_pkg::t_result      o_result
);

    localparam logic [30:0] TempScale  = 31'd17500;
    localparam logic [30:0] HumScale   = 31'd12500;
    localparam logic [16:0] WordMax    = 17'd65535;
    localparam logic [14:0] TempOffset = 15'd4500;
    localparam logic [14:0] HumOffset  = 15'd600;
    localparam logic [14:0] HumTop     = 15'd10600;
    localparam logic [13:0] HumMax     = 14'd10000;

    logic                  r_s1_valid;
    logic                  r_s1_ok;
    logic [30:0]           r_temp_prod;
    logic [30:0]           r_hum_prod;
    logic                  r_out_valid;
    htfd_pkg::t_result     r_result, n_result;
    logic signed [14:0]    r_last_temp;
    logic [13:0]           r_last_hum;
    logic                  r_seen;
    logic                  w_out_free;
    logic                  w_advance;
    logic [14:0]           w_temp_q;
    logic [14:0]           w_hum_q;
    logic signed [14:0]    w_temp;
    logic [13:0]           w_hum;

    // floor(x / 65535) for x below 32768 * 65535
    function automatic logic [14:0] div_word_max(input logic [30:0] x);
        logic [14:0] q;
        logic [16:0] r;
        q = x[30:16];
        r = {1'b0, x[15:0]} + {2'b00, q};
        return q + {14'd0, (r >= WordMax)};
    endfunction

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_s1_valid && w_out_free;
    assign o_stall    = r_s1_valid && !w_out_free;

    assign w_temp_q = div_word_max(r_temp_prod);
    assign w_hum_q  = div_word_max(r_hum_prod);
    assign w_temp   = $signed(w_temp_q - TempOffset);

    always_comb begin
        if (w_hum_q < HumOffset) begin
            w_hum = '0;
        end else if (w_hum_q > HumTop) begin
            w_hum = HumMax;
        end else begin
            w_hum = 14'(w_hum_q - HumOffset);
        end
    end

    always_comb begin
        n_result.temp_centi     = r_s1_ok ? w_temp : r_last_temp;
        n_result.humidity_centi = r_s1_ok ? w_hum : r_last_hum;
        n_result.crc_ok         = r_s1_ok;
        n_result.have_reading   = r_seen || r_s1_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_temp <= '0;
            r_last_hum  <= '0;
            r_seen      <= 1'b0;
        end else begin
            if (i_frame.done) begin
                r_s1_valid <= 1'b1;
            end else if (w_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_advance && r_s1_ok) begin
                r_last_temp <= w_temp;
                r_last_hum  <= w_hum;
                r_seen      <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.done) begin
            r_s1_ok     <= i_frame.ok;
            r_temp_prod <= TempScale * {15'd0, i_frame.temp_raw};
            r_hum_prod  <= HumScale * {15'd0, i_frame.humid_raw};
        end
        if (w_advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule
`default_nettype wire

// ===== hdl/humidity_temp_frame_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Checks the CRC-8 of a six-byte sensor reply and scales its temperature and
// humidity words into hundredths of a degree and of a percent.
// ----------------------------------------------------------------------------
// One byte is taken in every cycle while input ready is high. The sixth byte
// of a reply yields one reading: constant multipliers fill the multiplier
// stage, then divide-by-65535 correction and clamp fill the output register.
// Input ready drops only while a finished reading waits in the output
// register and the next one is already in the multiplier stage.
module humidity_temp_frame_decoder (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    htfd_in_if.sink     i_in,
    htfd_out_if.source  o_out
);

    htfd_pkg::t_frame  w_frame;
    htfd_pkg::t_result w_result;
    logic              w_stall;
    logic              w_accept;
    logic              w_out_valid;

    assign i_in.ready = !w_stall;
    assign w_accept   = i_in.valid && !w_stall;

    htfd_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_rx_byte     (i_in.rx_byte),
        .i_frame_start (i_in.frame_start),
        .o_frame       (w_frame)
    );

    htfd_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame     (w_frame),
        .i_out_ready (o_out.ready),
        .o_stall     (w_stall),
        .o_out_valid (w_out_valid),
        .o_result    (w_result)
    );

    assign o_out.valid          = w_out_valid;
    assign o_out.temp_centi     = w_result.temp_centi;
    assign o_out.humidity_centi = w_result.humidity_centi;
    assign o_out.crc_ok         = w_result.crc_ok;
    assign o_out.have_reading   = w_result.have_reading;

endmodule
`default_nettype wire

// ===== hdl/htfd_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_checker
// Port-level checks of the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module htfd_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_ready,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_ready,
    input wire logic signed [htfd_pkg::TempW-1:0] i_temp_centi,
    input wire logic [htfd_pkg::HumW-1:0]         i_humidity_centi,
    input wire logic                              i_crc_ok,
    input wire logic                              i_have_reading
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_humidity_centi <= 14'd10000)
        else $error("humidity above clamp");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_temp_centi >= -15'sd4500) && (i_temp_centi <= 15'sd13000))
        else $error("temperature out of range");

    a_ok_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_crc_ok |-> i_have_reading)
        else $error("good frame without reading flag");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_temp_centi     (o_out.temp_centi),
    .i_humidity_centi (o_out.humidity_centi),
    .i_crc_ok         (o_out.crc_ok),
    .i_have_reading   (o_out.have_reading)
);
`default_nettype wire

// ===== bench/humidity_temp_frame_decoder_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_tb
// Feeds six-byte sensor replies, broken replies and stray bytes into the frame
// decoder through its valid/ready byte channel. The bench tracks the CRC and
// the held readings on its own and compares every reading transfer against it.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_tb;

    typedef struct {
        logic [7:0] data;
        logic       start;
        logic       drain;
    } t_byte_req;

    logic i_clk = 1'b0;
    logic i_rst_n;

    htfd_in_if  in_if();
    htfd_out_if out_if();

    humidity_temp_frame_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #10 i_clk = ~i_clk;

    t_byte_req         byte_plan[$];
    htfd_pkg::t_result readings_due[$];

    // decoder shadow state
    htfd_pkg::t_pos                    frame_pos  = htfd_pkg::POS_T_HI;
    logic [7:0]                        crc_acc    = htfd_pkg::CrcInit;
    logic [7:0]                        hi_byte    = '0;
    logic [htfd_pkg::WordW-1:0]        temp_word  = '0;
    logic                              temp_ok    = 1'b0;
    logic [htfd_pkg::WordW-1:0]        humid_word = '0;
    logic signed [htfd_pkg::TempW-1:0] held_temp  = '0;
    logic [htfd_pkg::HumW-1:0]         held_humid = '0;
    logic                              seen_good  = 1'b0;

    int bytes_accepted   = 0;
    int readings_checked = 0;
    int good_frames      = 0;
    int rejected_frames  = 0;
    int drain_pauses     = 0;
    int fail_count       = 0;

    int burst_left = 1;
    int gap_left   = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int cycle_cnt  = 0;

    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            if (r[7] ^ data[i]) begin
                r = {r[6:0], 1'b0} ^ htfd_pkg::CrcPoly;
            end else begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(3100, 3200));
            3:       return 16'($urandom_range(57600, 57750));
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic plan_byte(input logic [7:0] data, input logic start, input logic drain);
        t_byte_req req;
        req.data  = data;
        req.start = start;
        req.drain = drain;
        byte_plan.push_back(req);
    endtask

    // queue the first keep bytes of a reply; flips corrupt the CRC bytes
    task automatic plan_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                              input logic [7:0] t_flip, input logic [7:0] h_flip,
                              input logic start, input logic drain, input int keep);
        logic [7:0] bytes [6];
        bytes[0] = t_raw[15:8];
        bytes[1] = t_raw[7:0];
        bytes[2] = crc8_next(crc8_next(htfd_pkg::CrcInit, t_raw[15:8]), t_raw[7:0])
                   ^ t_flip;
        bytes[3] = h_raw[15:8];
        bytes[4] = h_raw[7:0];
        bytes[5] = crc8_next(crc8_next(htfd_pkg::CrcInit, h_raw[15:8]), h_raw[7:0])
                   ^ h_flip;
        for (int i = 0; i < keep; i++) begin
            plan_byte(bytes[i], (i == 0) ? start : 1'b0, (i == 0) ? drain : 1'b0);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic start);
        htfd_pkg::t_result r;
        logic    good;
        int      t_val;
        int      h_val;
        bytes_accepted++;
        if (start) begin
            frame_pos = htfd_pkg::POS_T_HI;
        end
        case (frame_pos)
            htfd_pkg::POS_T_HI, htfd_pkg::POS_H_HI: begin
                crc_acc = crc8_next(htfd_pkg::CrcInit, b);
                hi_byte = b;
            end
            htfd_pkg::POS_T_LO: begin
                crc_acc   = crc8_next(crc_acc, b);
                temp_word = {hi_byte, b};
            end
            htfd_pkg::POS_H_LO: begin
                crc_acc    = crc8_next(crc_acc, b);
                humid_word = {hi_byte, b};
            end
            htfd_pkg::POS_T_CRC: begin
                temp_ok = (crc_acc == b);
            end
            htfd_pkg::POS_H_CRC: begin
                good = temp_ok && (crc_acc == b);
                if (good) begin
                    t_val = -4500 + (17500 * int'(temp_word)) / 65535;
                    h_val = -600 + (12500 * int'(humid_word)) / 65535;
                    if (h_val < 0) begin
                        h_val = 0;
                    end
                    if (h_val > 10000) begin
                        h_val = 10000;
                    end
                    held_temp  = t_val[htfd_pkg::TempW-1:0];
                    held_humid = h_val[htfd_pkg::HumW-1:0];
                    seen_good  = 1'b1;
                    good_frames++;
                end else begin
                    rejected_frames++;
                end
                r.temp_centi     = held_temp;
                r.humidity_centi = held_humid;
                r.crc_ok         = good;
                r.have_reading   = seen_good;
                readings_due.push_back(r);
            end
            default: begin
            end
        endcase
        if (frame_pos == htfd_pkg::POS_H_CRC) begin
            frame_pos = htfd_pkg::POS_T_HI;
        end else begin
            frame_pos = htfd_pkg::t_pos'(frame_pos + 3'd1);
        end
    endtask

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    task automatic check_reading();
        htfd_pkg::t_result want;
        if (readings_due.size() == 0) begin
            report_failure($sformatf("unexpected reading temp=%0d hum=%0d ok=%0b seen=%0b",
                out_if.temp_centi, out_if.humidity_centi, out_if.crc_ok,
                out_if.have_reading));
        end else begin
            want = readings_due.pop_front();
            readings_checked++;
            if (out_if.temp_centi !== want.temp_centi
                    || out_if.humidity_centi !== want.humidity_centi
                    || out_if.crc_ok !== want.crc_ok
                    || out_if.have_reading !== want.have_reading) begin
                report_failure({
                    $sformatf("reading %0d exp temp=%0d hum=%0d ok=%0b seen=%0b",
                        readings_checked, want.temp_centi, want.humidity_centi,
                        want.crc_ok, want.have_reading),
                    $sformatf(", got temp=%0d hum=%0d ok=%0b seen=%0b",
                        out_if.temp_centi, out_if.humidity_centi,
                        out_if.crc_ok, out_if.have_reading)});
            end
        end
    endtask

    // byte driver: bursts with gaps, optional drain pause before an item
    always @(posedge i_clk) begin
        t_byte_req next_req;
        if (!i_rst_n) begin
            in_if.valid       <= 1'b0;
            in_if.rx_byte     <= '0;
            in_if.frame_start <= 1'b0;
        end else if (!(in_if.valid && !in_if.ready)) begin
            if (in_if.valid) begin
                decode_byte(in_if.rx_byte, in_if.frame_start);
            end
            if (gap_left != 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (byte_plan.size() == 0
                    || (byte_plan[0].drain && readings_due.size() != 0)) begin
                in_if.valid <= 1'b0;
            end else begin
                next_req = byte_plan.pop_front();
                if (next_req.drain) begin
                    drain_pauses++;
                end
                in_if.valid       <= 1'b1;
                in_if.rx_byte     <= next_req.data;
                in_if.frame_start <= next_req.start;
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                             : $urandom_range(1, 12);
                    gap_left   = $urandom_range(1, 7);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // reading monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                check_reading();
            end
            cycle_cnt++;
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(64, 256);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0:       out_if.ready <= 1'b1;
                1:       out_if.ready <= 1'($urandom_range(0, 1));
                2:       out_if.ready <= ($urandom_range(0, 15) == 0);
                default: out_if.ready <= ((cycle_cnt % 7) < 3);
            endcase
        end
    end

    initial begin
        int kind;
        logic first_random;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.rx_byte     = '0;
        in_if.frame_start = 1'b0;
        out_if.ready      = 1'b0;

        // rejected reply before any good one
        plan_frame(16'h6A5C, 16'h7F21, 8'h01, 8'h00, 1'b1, 1'b0, 6);
        // good reply without frame_start right after a full one: low extremes
        plan_frame(16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 6);
        // partial reply cut short by frame_start, then high extremes
        plan_frame(16'h1234, 16'h5678, 8'h00, 8'h00, 1'b1, 1'b0, 3);
        plan_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 1'b1, 1'b0, 6);
        // bad humidity CRC: values held
        plan_frame(16'h8000, 16'h6666, 8'h00, 8'hFF, 1'b0, 1'b0, 6);

        first_random = 1'b1;
        while (byte_plan.size() < 1850) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                plan_frame(pick_raw(), pick_raw(), 8'h00, 8'h00, ($urandom_range(0, 3) != 0),
                           first_random || ($urandom_range(0, 39) == 0), 6);
                first_random = 1'b0;
            end else if (kind < 82) begin
                case ($urandom_range(0, 2))
                    0: plan_frame(pick_raw(), pick_raw(), 8'($urandom_range(1, 255)), 8'h00,
                                  1'($urandom_range(0, 1)), 1'b0, 6);
                    1: plan_frame(pick_raw(), pick_raw(), 8'h00, 8'($urandom_range(1, 255)),
                                  1'($urandom_range(0, 1)), 1'b0, 6);
                    default: plan_frame(pick_raw(), pick_raw(), 8'($urandom_range(1, 255)),
                                        8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)),
                                        1'b0, 6);
                endcase
            end else if (kind < 92) begin
                plan_frame(pick_raw(), pick_raw(), 8'h00, 8'h00, 1'b1, 1'b0,
                           $urandom_range(1, 5));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    plan_byte(8'($urandom()), 1'($urandom_range(0, 1)), 1'b0);
                end
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_plan.size() != 0 || in_if.valid) begin
            @(posedge i_clk);
        end
        while (readings_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (readings_due.size() != 0) begin
            report_failure($sformatf("%0d readings never arrived", readings_due.size()));
        end

        $display("Run covered %0d byte transfers and %0d readings (%0d good, %0d rejected).",
                 bytes_accepted, readings_checked, good_frames, rejected_frames);
        $display("Sender drained the decoder %0d times; %0d failures seen.",
                 drain_pauses, fail_count);
        if (fail_count == 0) begin
            $display("** humidity_temp_frame_decoder: PASSED **");
        end else begin
            $display("** humidity_temp_frame_decoder: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout: run did not complete.");
        $display("** humidity_temp_frame_decoder: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/htfd_pkg.sv
hdl/htfd_if.sv
hdl/htfd_frame.sv
hdl/htfd_scale.sv
hdl/humidity_temp_frame_decoder.sv
hdl/htfd_checker.sv
bench/humidity_temp_frame_decoder_tb.sv
